// File: rtl/tseid_pkg.sv
`default_nettype none
package tseid_pkg;

  // Default screen geometry.
  localparam int ROWS_DEFAULT    = 32;
  localparam int COLUMNS_DEFAULT = 64;

  // Fill byte for erased and cleared cells.
  localparam logic [7:0] BLANK = 8'h20;

  // Operation codes carried by the mode field.
  localparam logic [2:0] MODE_ERASE_DISPLAY = 3'd0;
  localparam logic [2:0] MODE_ERASE_LINE    = 3'd1;
  localparam logic [2:0] MODE_INSERT_LINES  = 3'd2;
  localparam logic [2:0] MODE_DELETE_LINES  = 3'd3;
  localparam logic [2:0] MODE_WRITE_CELL    = 3'd4;
  localparam logic [2:0] MODE_READ_CELL     = 3'd5;

  // Erase spans carried by the extent field.
  localparam logic [1:0] EXT_TO_END     = 2'd0;
  localparam logic [1:0] EXT_FROM_START = 2'd1;
  localparam logic [1:0] EXT_ALL        = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch the input item and set up its sweep
    logic step;      // process one cell of the sweep
    logic out_load;  // move the finished result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_cell;  // the current cell is the final one of the sweep
  } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/tseid_ram.sv
`default_nettype none
module tseid_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 11
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/tseid_ctrl.sv
`default_nettype none
module tseid_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output tseid_pkg::ctrl_cmd_t       cmd,
  input  wire tseid_pkg::dp_status_t status
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_stall     = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.step = 1'b1;
        if (status.last_cell) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (status.last_cell) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tseid_datapath.sv
`default_nettype none
module tseid_datapath #(
  parameter int ROWS    = tseid_pkg::ROWS_DEFAULT,
  parameter int COLUMNS = tseid_pkg::COLUMNS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tseid_pkg::ctrl_cmd_t cmd,
  output tseid_pkg::dp_status_t     status,
  input  wire logic [2:0]           mode,
  input  wire logic [1:0]           extent,
  input  wire logic [5:0]           line_count,
  input  wire logic [4:0]           cursor_row,
  input  wire logic [5:0]           cursor_col,
  input  wire logic [7:0]           char_code,
  output logic      [7:0]           char_out
);

  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int AW   = RW + CW;
  localparam int CNTW = ($clog2(ROWS + 1) + 1 > 6) ? $clog2(ROWS + 1) + 1 : 6;
  // One bit above the wider of the column counter and the column field, so
  // that COLUMNS itself fits for the bounds check.
  localparam int CMPW = ((CW > 6) ? CW : 6) + 1;

  localparam logic [RW-1:0]   ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0]   COL_LAST = CW'(COLUMNS - 1);
  localparam logic [CNTW-1:0] ROWS_C   = CNTW'(ROWS);

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_BLANK,
    ACT_COPY,
    ACT_CODE,
    ACT_READ
  } act_t;

  // Latched item.
  logic [2:0]      mode_q;
  logic [1:0]      ext_q;
  logic [RW-1:0]   row_q;
  logic [5:0]      col_q;
  logic [7:0]      code_q;
  logic [CNTW-1:0] n_q;
  logic            row_ok_q;
  logic            col_ok_q;

  // Sweep state.
  logic            clearing;
  logic [RW-1:0]   r;
  logic [CW-1:0]   c;
  logic [RW-1:0]   r_last;
  logic            down;
  logic            single;

  // Write and read stage behind the memory read.
  logic            wr_pend;
  logic            wr_copy;
  logic            wr_code;
  logic [AW-1:0]   wr_addr;
  logic            rd_pend;
  logic [7:0]      result_q;

  logic [7:0]      rdata;
  logic [7:0]      wdata;
  logic [AW-1:0]   raddr;

  // Setup values computed from the incoming item.
  logic [CNTW-1:0] row_in_x;
  logic [CNTW-1:0] room;
  logic [CNTW-1:0] cnt_in;
  logic [RW-1:0]   row_in;
  logic [RW-1:0]   r0;
  logic [RW-1:0]   rl0;
  logic            dn0;
  logic            sg0;

  // Per-cell decision.
  logic [CNTW-1:0] r_x;
  logic [CNTW-1:0] row_x;
  logic [CMPW-1:0] c_x;
  logic [CMPW-1:0] col_x;
  logic            after_cur;
  logic            before_cur;
  logic            erase_hit;
  logic [CNTW-1:0] src_x;
  logic            copy_ok;
  logic            c_end;
  act_t            act;

  always_comb begin
    row_in_x = CNTW'(cursor_row);
    room     = ROWS_C - row_in_x;
    cnt_in   = CNTW'(line_count);
    row_in   = RW'(cursor_row);
    r0       = row_in;
    rl0      = row_in;
    dn0      = 1'b0;
    sg0      = 1'b0;
    case (mode)
      tseid_pkg::MODE_ERASE_DISPLAY: begin
        r0  = '0;
        rl0 = ROW_LAST;
      end
      tseid_pkg::MODE_ERASE_LINE: begin
        r0  = row_in;
        rl0 = row_in;
      end
      tseid_pkg::MODE_INSERT_LINES: begin
        r0  = ROW_LAST;
        rl0 = row_in;
        dn0 = 1'b1;
      end
      tseid_pkg::MODE_DELETE_LINES: begin
        r0  = row_in;
        rl0 = ROW_LAST;
      end
      default: begin
        sg0 = 1'b1;
      end
    endcase
  end

  always_comb begin
    r_x        = CNTW'(r);
    row_x      = CNTW'(row_q);
    c_x        = CMPW'(c);
    col_x      = CMPW'(col_q);
    after_cur  = (r_x > row_x) || ((r_x == row_x) && (c_x >= col_x));
    before_cur = (r_x < row_x) || ((r_x == row_x) && (c_x <= col_x));
    case (ext_q)
      tseid_pkg::EXT_TO_END:     erase_hit = col_ok_q && after_cur;
      tseid_pkg::EXT_FROM_START: erase_hit = col_ok_q && before_cur;
      tseid_pkg::EXT_ALL:        erase_hit = 1'b1;
      default:                   erase_hit = 1'b0;
    endcase
    if (mode_q == tseid_pkg::MODE_INSERT_LINES) begin
      src_x   = r_x - n_q;
      copy_ok = r_x >= (row_x + n_q);
    end else begin
      src_x   = r_x + n_q;
      copy_ok = (r_x + n_q) < ROWS_C;
    end

    act = ACT_NONE;
    if (clearing) begin
      act = ACT_BLANK;
    end else if (row_ok_q) begin
      case (mode_q)
        tseid_pkg::MODE_ERASE_DISPLAY,
        tseid_pkg::MODE_ERASE_LINE: begin
          act = erase_hit ? ACT_BLANK : ACT_NONE;
        end
        tseid_pkg::MODE_INSERT_LINES,
        tseid_pkg::MODE_DELETE_LINES: begin
          if (n_q != '0) begin
            act = copy_ok ? ACT_COPY : ACT_BLANK;
          end
        end
        tseid_pkg::MODE_WRITE_CELL: begin
          act = col_ok_q ? ACT_CODE : ACT_NONE;
        end
        tseid_pkg::MODE_READ_CELL: begin
          act = col_ok_q ? ACT_READ : ACT_NONE;
        end
        default: begin
          act = ACT_NONE;
        end
      endcase
    end

    c_end            = single || (c == COL_LAST);
    status.last_cell = c_end && (r == r_last);
    raddr            = {(act == ACT_COPY) ? RW'(src_x) : r, c};
  end

  // Sweep counters and latched item.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      r        <= '0;
      c        <= '0;
      r_last   <= ROW_LAST;
      down     <= 1'b0;
      single   <= 1'b0;
    end else if (cmd.load) begin
      clearing <= 1'b0;
      r        <= r0;
      c        <= sg0 ? CW'(cursor_col) : '0;
      r_last   <= rl0;
      down     <= dn0;
      single   <= sg0;
    end else if (cmd.step) begin
      if (c_end) begin
        c <= single ? c : '0;
        r <= down ? r - 1'b1 : r + 1'b1;
      end else begin
        c <= c + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= mode;
      ext_q    <= extent;
      row_q    <= row_in;
      col_q    <= cursor_col;
      code_q   <= char_code;
      n_q      <= (cnt_in > room) ? room : cnt_in;
      row_ok_q <= row_in_x < ROWS_C;
      col_ok_q <= CMPW'(cursor_col) < CMPW'(COLUMNS);
    end
  end

  // Write stage: the cell decided in one cycle is written in the next,
  // when the copy source has come out of the memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.step && ((act == ACT_BLANK) || (act == ACT_COPY) ||
                              (act == ACT_CODE));
      rd_pend <= cmd.step && (act == ACT_READ);
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= {r, c};
    wr_copy <= act == ACT_COPY;
    wr_code <= act == ACT_CODE;
  end

  assign wdata = wr_copy ? rdata : (wr_code ? code_q : tseid_pkg::BLANK);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result_q <= '0;
    end else if (rd_pend) begin
      result_q <= rdata;
    end
    if (cmd.out_load) begin
      char_out <= result_q;
    end
  end

  tseid_ram #(
    .WIDTH  (8),
    .ADDR_W (AW)
  ) u_screen (
    .clk   (clk),
    .we    (wr_pend),
    .waddr (wr_addr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule
`default_nettype wire

// File: rtl/text_screen_erase_insert_delete_unit.sv
`default_nettype none
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  mode, extent, line_count, cursor_row,
//                                          cursor_col, char_code
// output   out        out_valid / out_stall char_out
//
// Each item walks the cells it touches one cell per cycle through the single
// write port of the screen memory. Erase display walks ROWS*COLUMNS cells,
// insert or delete lines walk the rows from the cursor row to the bottom,
// (ROWS - cursor_row)*COLUMNS cells, erase line walks COLUMNS cells, and the
// cell and idle operations walk one cell; the next item is accepted only
// after the walk, the drain and the result handoff. After reset all cells of
// the memory are swept to spaces, during which no item is accepted. A result
// waiting in the output register under out_stall does not hold up the next
// accept; only that next item's finish waits for the register to free up.
module text_screen_erase_insert_delete_unit #(
  parameter int ROWS    = tseid_pkg::ROWS_DEFAULT,
  parameter int COLUMNS = tseid_pkg::COLUMNS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] mode,
  input  wire logic [1:0] extent,
  input  wire logic [5:0] line_count,
  input  wire logic [4:0] cursor_row,
  input  wire logic [5:0] cursor_col,
  input  wire logic [7:0] char_code,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] char_out
);

  // The controller sequences the clearing sweep, the per-item cell walk, a
  // drain state for the last memory write and read, and the result handoff.
  tseid_pkg::ctrl_cmd_t  cmd;
  tseid_pkg::dp_status_t status;

  tseid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the item, the row and column walk counters, the
  // screen memory and the output register. Line shifts read the source row
  // and write the destination row in the following cycle, walking in the direction
  // that never reads a row already overwritten.
  tseid_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .mode       (mode),
    .extent     (extent),
    .line_count (line_count),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .char_code  (char_code),
    .char_out   (char_out)
  );

endmodule
`default_nettype wire
